FILE: src/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// Widths, constants and calendar tables shared by the interfaces and the
// date difference pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned CUM_W   = 9;
  localparam int unsigned Q100_W  = 8;

  localparam int unsigned YEAR_MAX = 9999;
  localparam int unsigned MONTH_FEB = 2;
  localparam int unsigned MONTH_DEC = 12;

  // Multiplication by 5243 and a shift by 19 gives floor(y / 100) exactly
  // for every year that the field can hold.
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned PROD_W      = YEAR_W + 13;

  // Days before the first of the month in a common year.
  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
    logic [CUM_W-1:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: src/dbd_if.sv
// ----------------------------------------------------------------------------
// dbd_if
// Valid/ready channels: a pair of dates in, a day count and error flag out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbd_in_if;
  logic                          valid;
  logic                          ready;
  logic [dbd_pkg::DAY_W-1:0]     first_day;
  logic [dbd_pkg::MONTH_W-1:0]   first_month;
  logic [dbd_pkg::YEAR_W-1:0]    first_year;
  logic [dbd_pkg::DAY_W-1:0]     second_day;
  logic [dbd_pkg::MONTH_W-1:0]   second_month;
  logic [dbd_pkg::YEAR_W-1:0]    second_year;

  modport source (output valid, first_day, first_month, first_year,
                  second_day, second_month, second_year, input ready);
  modport sink   (input valid, first_day, first_month, first_year,
                  second_day, second_month, second_year, output ready);
endinterface

interface dbd_out_if;
  logic                          valid;
  logic                          ready;
  logic [dbd_pkg::COUNT_W-1:0]   day_count;
  logic                          date_error;

  modport source (output valid, day_count, date_error, input ready);
  modport sink   (input valid, day_count, date_error, output ready);
endinterface

`default_nettype wire

FILE: src/days_between_dates.sv
// ----------------------------------------------------------------------------
// days_between_dates
// Absolute number of days between two Gregorian dates, with date validation.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Contents
//  ---------+-----------+------------------------------------------------
//  dates    | in        | first/second day, month, year
//  result   | out       | day_count, date_error (count is 0 on error)
//
//  Four register stages: year quotients, leap and year offset, day number,
//  difference. An accepted transaction passes through them in that order,
//  and its result is held in the last stage until the result is taken.
//  One transaction can be accepted every cycle unless a stalled result
//  holds the pipeline; each of the four stages has its own valid bit.
//  A stage moves on when it is empty or the stage after it moves, so a
//  stalled result holds the pipeline while bubbles ahead of it still fill.
//  Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module days_between_dates (
  input  wire logic clk,
  input  wire logic rst,
  dbd_in_if.sink    dates,
  dbd_out_if.source result
);

  localparam int unsigned LANES = 2;

  // Stage enables.
  logic adv1, adv2, adv3, adv4;

  // Stage 1: quotient by 100 and 365 * (year - 1).
  logic                              s1_valid;
  logic [dbd_pkg::DAY_W-1:0]         s1_day   [LANES];
  logic [dbd_pkg::MONTH_W-1:0]       s1_month [LANES];
  logic [dbd_pkg::YEAR_W-1:0]        s1_year  [LANES];
  logic [dbd_pkg::Q100_W-1:0]        s1_q100  [LANES];
  logic [dbd_pkg::COUNT_W-1:0]       s1_y365  [LANES];

  // Stage 2: days before the year, leap flag, validity.
  logic                              s2_valid;
  logic [dbd_pkg::DAY_W-1:0]         s2_day   [LANES];
  logic [dbd_pkg::MONTH_W-1:0]       s2_month [LANES];
  logic                              s2_leap  [LANES];
  logic                              s2_ok    [LANES];
  logic [dbd_pkg::COUNT_W-1:0]       s2_nyear [LANES];

  // Stage 3: ordinal day numbers.
  logic                              s3_valid;
  logic                              s3_ok;
  logic [dbd_pkg::COUNT_W-1:0]       s3_num   [LANES];

  // Stage 4 is the output register.
  logic                              s4_valid;
  logic                              s4_error;
  logic [dbd_pkg::COUNT_W-1:0]       s4_count;

  logic [dbd_pkg::DAY_W-1:0]         in_day   [LANES];
  logic [dbd_pkg::MONTH_W-1:0]       in_month [LANES];
  logic [dbd_pkg::YEAR_W-1:0]        in_year  [LANES];

  logic [dbd_pkg::Q100_W-1:0]        q100_next  [LANES];
  logic [dbd_pkg::COUNT_W-1:0]       y365_next  [LANES];
  logic [dbd_pkg::COUNT_W-1:0]       nyear_next [LANES];
  logic                              leap_next  [LANES];
  logic                              ok_next    [LANES];
  logic [dbd_pkg::COUNT_W-1:0]       num_next   [LANES];
  logic [dbd_pkg::COUNT_W-1:0]       count_next;

  assign adv4 = !s4_valid || result.ready;
  assign adv3 = !s3_valid || adv4;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;

  assign dates.ready       = adv1;
  assign result.valid      = s4_valid;
  assign result.day_count  = s4_count;
  assign result.date_error = s4_error;

  assign in_day[0]   = dates.first_day;
  assign in_month[0] = dates.first_month;
  assign in_year[0]  = dates.first_year;
  assign in_day[1]   = dates.second_day;
  assign in_month[1] = dates.second_month;
  assign in_year[1]  = dates.second_year;

  // Stage 1 logic.
  always_comb begin
    logic [dbd_pkg::PROD_W-1:0] prod;
    logic [dbd_pkg::YEAR_W-1:0] prev;
    for (int i = 0; i < LANES; i++) begin
      prod = dbd_pkg::PROD_W'(in_year[i]) * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);
      q100_next[i] = prod[dbd_pkg::RECIP_SHIFT +: dbd_pkg::Q100_W];
      prev = in_year[i] - dbd_pkg::YEAR_W'(1);
      y365_next[i] = dbd_pkg::COUNT_W'(prev) * dbd_pkg::COUNT_W'(365);
    end
  end

  // Stage 2 logic. The quotient of year - 1 by 100 is one less than that of
  // the year when the year is a whole century; the quotient by 400 follows
  // from it by a shift.
  always_comb begin
    logic [dbd_pkg::YEAR_W-1:0]  rem;
    logic                        cent;
    logic [dbd_pkg::YEAR_W-1:0]  prev;
    logic [dbd_pkg::Q100_W-1:0]  p100;
    logic                        leap;
    for (int i = 0; i < LANES; i++) begin
      rem  = s1_year[i] - dbd_pkg::YEAR_W'(dbd_pkg::YEAR_W'(s1_q100[i]) *
                                          dbd_pkg::YEAR_W'(100));
      cent = (rem == '0);
      leap = cent ? (s1_q100[i][1:0] == 2'b00) : (s1_year[i][1:0] == 2'b00);
      prev = s1_year[i] - dbd_pkg::YEAR_W'(1);
      p100 = s1_q100[i] - dbd_pkg::Q100_W'(cent);
      leap_next[i]  = leap;
      nyear_next[i] = s1_y365[i] + dbd_pkg::COUNT_W'(prev >> 2)
                      - dbd_pkg::COUNT_W'(p100) + dbd_pkg::COUNT_W'(p100 >> 2);
      ok_next[i] = (s1_year[i] != '0)
                   && (s1_year[i] <= dbd_pkg::YEAR_W'(dbd_pkg::YEAR_MAX))
                   && (s1_month[i] != '0)
                   && (s1_month[i] <= dbd_pkg::MONTH_W'(dbd_pkg::MONTH_DEC))
                   && (s1_day[i] != '0)
                   && (s1_day[i] <= dbd_pkg::month_len(s1_month[i], leap));
    end
  end

  // Stage 3 logic.
  always_comb begin
    logic extra;
    for (int i = 0; i < LANES; i++) begin
      extra = s2_leap[i] && (s2_month[i] > dbd_pkg::MONTH_W'(dbd_pkg::MONTH_FEB));
      num_next[i] = s2_nyear[i] + dbd_pkg::COUNT_W'(dbd_pkg::cum_days(s2_month[i]))
                    + dbd_pkg::COUNT_W'(extra) + dbd_pkg::COUNT_W'(s2_day[i]);
    end
  end

  // Stage 4 logic.
  always_comb begin
    if (!s3_ok) begin
      count_next = '0;
    end else if (s3_num[0] > s3_num[1]) begin
      count_next = s3_num[0] - s3_num[1];
    end else begin
      count_next = s3_num[1] - s3_num[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= dates.valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
      if (adv4) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (adv1) begin
        s1_day[i]   <= in_day[i];
        s1_month[i] <= in_month[i];
        s1_year[i]  <= in_year[i];
        s1_q100[i]  <= q100_next[i];
        s1_y365[i]  <= y365_next[i];
      end
      if (adv2) begin
        s2_day[i]   <= s1_day[i];
        s2_month[i] <= s1_month[i];
        s2_leap[i]  <= leap_next[i];
        s2_ok[i]    <= ok_next[i];
        s2_nyear[i] <= nyear_next[i];
      end
      if (adv3) begin
        s3_num[i] <= num_next[i];
      end
    end
    if (adv3) begin
      s3_ok <= s2_ok[0] && s2_ok[1];
    end
    if (adv4) begin
      s4_count <= count_next;
      s4_error <= !s3_ok;
    end
  end

  // An error result always carries a zero count.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    s4_valid && s4_error |-> s4_count == '0)
    else $error("error result with non-zero day count");

  // A valid count never exceeds the span of the calendar.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !s4_error |-> s4_count <= dbd_pkg::COUNT_W'(3652058))
    else $error("day count out of range");

  // A blocked first stage keeps its transaction.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv2 |=> s1_valid && $stable(s1_year[0]) && $stable(s1_year[1]))
    else $error("first stage lost or changed a stalled transaction");

  // An empty first stage always takes a new transaction.
  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> dates.ready)
    else $error("input stalled with an empty first stage");

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
